/* rtl/cbd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_pkg: shared definitions of the circular byte deque
// Store depth, derived widths, action and status codes, and the command
// bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic load;   // capture the incoming item
    logic exec;   // apply the captured action to indices, count and store
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/cbd_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_ctrl: sequencer of the circular byte deque
// Walks each item through capture, execution and result cycles and drives
// the busy and done handshake signals.
// ----------------------------------------------------------------------------
module cbd_ctrl (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output cbd_pkg::cmd_t cmd_o,
  output logic        busy_o,
  output logic        done_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_q <= S_RESP;
          done_q  <= 1'b1;
        end
        S_RESP: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.load = (state_q == S_IDLE) && start_i;
    cmd_o.exec = (state_q == S_EXEC);
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

/* rtl/cbd_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cbd_datapath: indices, count and byte store of the circular byte deque
// Holds the front and rear indices, the entry count and the store, and
// forms the result fields of each item.
// ----------------------------------------------------------------------------
module cbd_datapath (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  cbd_pkg::cmd_t             cmd_i,
  input  wire  [2:0]                action_i,
  input  wire  [7:0]                push_value_i,
  output logic [7:0]                data_out_o,
  output logic [1:0]                status_o,
  output logic [cbd_pkg::CntW-1:0]  item_count_o,
  output logic                      is_empty_o,
  output logic                      is_full_o
);

  localparam logic [cbd_pkg::IdxW-1:0] IdxLast = cbd_pkg::IdxW'(cbd_pkg::Depth - 1);
  localparam logic [cbd_pkg::CntW-1:0] CntFull = cbd_pkg::CntW'(cbd_pkg::Depth);

  logic [7:0] mem [cbd_pkg::Depth];

  cbd_pkg::action_e           act_q;
  logic [7:0]                 val_q;
  logic [cbd_pkg::IdxW-1:0]   front_q, front_d;
  logic [cbd_pkg::IdxW-1:0]   rear_q, rear_d;
  logic [cbd_pkg::CntW-1:0]   count_q, count_d;
  cbd_pkg::status_e           status_q, status_d;
  logic                       rd_ok_q;
  logic [7:0]                 rd_data_q;

  logic                       wr_en, rd_en;
  logic [cbd_pkg::IdxW-1:0]   wr_addr, rd_addr;
  logic [cbd_pkg::IdxW-1:0]   front_inc, front_dec, rear_inc, rear_dec;
  logic                       full, empty;

  assign full  = (count_q == CntFull);
  assign empty = (count_q == '0);

  // Index wrap written as compares so that any depth works, not only powers of two.
  assign front_inc = (front_q == IdxLast) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? IdxLast : front_q - 1'b1;
  assign rear_inc  = (rear_q == IdxLast) ? '0 : rear_q + 1'b1;
  assign rear_dec  = (rear_q == '0) ? IdxLast : rear_q - 1'b1;

  always_comb begin
    front_d  = front_q;
    rear_d   = rear_q;
    count_d  = count_q;
    status_d = cbd_pkg::ST_DONE;
    wr_en    = 1'b0;
    wr_addr  = front_dec;
    rd_en    = 1'b0;
    rd_addr  = front_q;
    unique case (act_q)
      cbd_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          status_d = cbd_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = front_dec;
          front_d = front_dec;
          count_d = count_q + 1'b1;
        end
      end
      cbd_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          status_d = cbd_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = rear_inc;
          rear_d  = rear_inc;
          count_d = count_q + 1'b1;
        end
      end
      cbd_pkg::ACT_POP_FRONT: begin
        if (empty) begin
          status_d = cbd_pkg::ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = front_q;
          front_d = front_inc;
          count_d = count_q - 1'b1;
        end
      end
      cbd_pkg::ACT_POP_BACK: begin
        if (empty) begin
          status_d = cbd_pkg::ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rear_q;
          rear_d  = rear_dec;
          count_d = count_q - 1'b1;
        end
      end
      cbd_pkg::ACT_PEEK_FRONT: begin
        if (empty) begin
          status_d = cbd_pkg::ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = front_q;
        end
      end
      cbd_pkg::ACT_PEEK_BACK: begin
        if (empty) begin
          status_d = cbd_pkg::ST_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rear_q;
        end
      end
      default: begin
        // Codes without a meaning leave the deque alone and report done.
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= cbd_pkg::action_e'(action_i);
      val_q <= push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[wr_addr] <= val_q;
    end
    if (cmd_i.exec && rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      rear_q   <= IdxLast;
      count_q  <= '0;
      status_q <= cbd_pkg::ST_DONE;
      rd_ok_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      rear_q   <= rear_d;
      count_q  <= count_d;
      status_q <= status_d;
      rd_ok_q  <= rd_en;
    end
  end

  assign data_out_o   = rd_ok_q ? rd_data_q : 8'd0;
  assign status_o     = status_q;
  assign item_count_o = count_q;
  assign is_empty_o   = (count_q == '0);
  assign is_full_o    = (count_q == CntFull);

endmodule
`default_nettype wire

/* rtl/circular_byte_deque_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// circular_byte_deque_unit: double-ended byte queue in a circular store
// Pushes, pops and peeks at either end of a 16-entry byte deque and reports
// status, entry count and empty and full flags for every item.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+----------------------------------
//   command  | start_i taken when !busy_o | action_i, push_value_i
//   result   | done_o, one cycle, no stall| data_out_o, status_o,
//            |                            | item_count_o, is_empty_o, is_full_o
//
// Each item passes through capture, execution with the store access, and the
// result cycle in which done_o is high; busy_o stays high in execution and
// result, so a new item is taken only once the last is through. The store
// read is registered, which sets the execution cycle apart from the result.
// Reset zeroes the front index and count, sets the rear index to the last
// entry; the store is not reset or cleared. The result cannot be held off.
// ----------------------------------------------------------------------------
module circular_byte_deque_unit (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  output logic                      busy_o,
  input  wire  [2:0]                action_i,
  input  wire  [7:0]                push_value_i,
  output logic                      done_o,
  output logic [7:0]                data_out_o,
  output logic [1:0]                status_o,
  output logic [cbd_pkg::CntW-1:0]  item_count_o,
  output logic                      is_empty_o,
  output logic                      is_full_o
);

  cbd_pkg::cmd_t cmd;

  cbd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  cbd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (action_i),
    .push_value_i (push_value_i),
    .data_out_o   (data_out_o),
    .status_o     (status_o),
    .item_count_o (item_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

`ifndef SYNTHESIS
  // An accepted item yields its result once the controller has passed through its execution state.
  a_result_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("result not delivered two cycles after an accepted item");

  // The result cycle belongs to the busy window.
  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done raised outside the busy window");

  // A rejected action returns no data.
  a_reject_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != cbd_pkg::ST_DONE |-> data_out_o == 8'd0)
    else $error("rejected action returned data");

  // The count never exceeds the depth and the full flag agrees with it.
  a_count_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_count_o <= cbd_pkg::CntW'(cbd_pkg::Depth) &&
    is_full_o == (item_count_o == cbd_pkg::CntW'(cbd_pkg::Depth)))
    else $error("entry count out of range or full flag inconsistent");
`endif

endmodule
`default_nettype wire

/* dv/circular_byte_deque_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_byte_deque_unit_tb: self-checking regression of the byte deque
// Drives pushes, pops, peeks and unused action codes with random idle gaps,
// predicts every result with a shadow deque and compares each field of the
// one-cycle result against the oldest prediction.
// ----------------------------------------------------------------------------
module circular_byte_deque_unit_tb;

  localparam int unsigned Depth     = cbd_pkg::Depth;
  localparam int unsigned CntW      = cbd_pkg::CntW;
  localparam logic [2:0] ActSpareLo = 3'd6;
  localparam logic [2:0] ActSpareHi = 3'd7;
  localparam int unsigned BlockLen  = 64;

  typedef struct {
    logic [7:0]        data;
    cbd_pkg::status_e  status;
    logic [CntW-1:0]   count;
    logic              empty;
    logic              full;
  } deque_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start_i = 1'b0;
  logic [2:0]      action_i = 3'd0;
  logic [7:0]      push_value_i = 8'd0;
  logic            busy_o;
  logic            done_o;
  logic [7:0]      data_out_o;
  logic [1:0]      status_o;
  logic [CntW-1:0] item_count_o;
  logic            is_empty_o;
  logic            is_full_o;

  // Shadow copy of the deque.
  logic [7:0]    shadow_store [Depth];
  int unsigned   front_pos = 0;
  int unsigned   rear_pos = Depth - 1;
  int unsigned   held_count = 0;

  deque_result_t pending_results[$];
  deque_result_t oldest;
  int unsigned   error_count = 0;

  circular_byte_deque_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .push_value_i (push_value_i),
    .done_o       (done_o),
    .data_out_o   (data_out_o),
    .status_o     (status_o),
    .item_count_o (item_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic deque_result_t apply_deque_action(logic [2:0] act, logic [7:0] val);
    deque_result_t res;
    logic          was_full;
    logic          was_empty;
    was_full   = (held_count >= Depth);
    was_empty  = (held_count == 0);
    res.data   = 8'd0;
    res.status = cbd_pkg::ST_DONE;
    case (act)
      cbd_pkg::ACT_PUSH_FRONT: begin
        if (was_full) begin
          res.status = cbd_pkg::ST_FULL;
        end else begin
          front_pos = (front_pos + Depth - 1) % Depth;
          shadow_store[front_pos] = val;
          held_count++;
        end
      end
      cbd_pkg::ACT_PUSH_BACK: begin
        if (was_full) begin
          res.status = cbd_pkg::ST_FULL;
        end else begin
          rear_pos = (rear_pos + 1) % Depth;
          shadow_store[rear_pos] = val;
          held_count++;
        end
      end
      cbd_pkg::ACT_POP_FRONT: begin
        if (was_empty) begin
          res.status = cbd_pkg::ST_EMPTY;
        end else begin
          res.data = shadow_store[front_pos];
          front_pos = (front_pos + 1) % Depth;
          held_count--;
        end
      end
      cbd_pkg::ACT_POP_BACK: begin
        if (was_empty) begin
          res.status = cbd_pkg::ST_EMPTY;
        end else begin
          res.data = shadow_store[rear_pos];
          rear_pos = (rear_pos + Depth - 1) % Depth;
          held_count--;
        end
      end
      cbd_pkg::ACT_PEEK_FRONT: begin
        if (was_empty) res.status = cbd_pkg::ST_EMPTY;
        else res.data = shadow_store[front_pos];
      end
      cbd_pkg::ACT_PEEK_BACK: begin
        if (was_empty) res.status = cbd_pkg::ST_EMPTY;
        else res.data = shadow_store[rear_pos];
      end
      default: begin
      end
    endcase
    res.count = held_count[CntW-1:0];
    res.empty = (held_count == 0);
    res.full  = (held_count >= Depth);
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Busy only moves at the rising edge, so a command that sees busy low at the
  // falling edge is taken at the next rising edge.
  task automatic send_item(logic [2:0] act, logic [7:0] val, int unsigned gap);
    @(negedge clk_i);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    action_i     <= act;
    push_value_i <= val;
    while (busy_o) @(negedge clk_i);
    pending_results.push_back(apply_deque_action(act, val));
    @(posedge clk_i);
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("[%0t] result with no item outstanding", $realtime);
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (data_out_o !== oldest.data)
          report_mismatch("data_out", data_out_o, oldest.data);
        if (status_o !== oldest.status)
          report_mismatch("status", status_o, oldest.status);
        if (item_count_o !== oldest.count)
          report_mismatch("item_count", item_count_o, oldest.count);
        if (is_empty_o !== oldest.empty)
          report_mismatch("is_empty", is_empty_o, oldest.empty);
        if (is_full_o !== oldest.full)
          report_mismatch("is_full", is_full_o, oldest.full);
      end
    end
  end

  // Rejections on the empty deque, unused codes, and single-entry round trips
  // at both ends, starting from the reset indices.
  task automatic test_empty_edges();
    send_item(cbd_pkg::ACT_POP_FRONT, 8'hA5, 0);
    send_item(cbd_pkg::ACT_POP_BACK, 8'h5A, 0);
    send_item(cbd_pkg::ACT_PEEK_FRONT, 8'hFF, 3);
    send_item(cbd_pkg::ACT_PEEK_BACK, 8'h00, 0);
    send_item(ActSpareLo, 8'hFF, 1);
    send_item(cbd_pkg::ACT_PUSH_FRONT, 8'h00, 0);
    send_item(cbd_pkg::ACT_POP_BACK, 8'h00, 0);
    send_item(cbd_pkg::ACT_PUSH_BACK, 8'hFF, 2);
    send_item(cbd_pkg::ACT_POP_FRONT, 8'h00, 0);
  endtask

  // Fill the deque from both ends, then hit it with pushes and an unused code while full.
  task automatic test_full_edges();
    logic [7:0] val;
    for (int unsigned i = 0; i < Depth; i++) begin
      case (i % 3)
        0: val = 8'hFF;
        1: val = 8'h00;
        default: val = 8'($urandom);
      endcase
      send_item((i % 2 == 0) ? cbd_pkg::ACT_PUSH_FRONT : cbd_pkg::ACT_PUSH_BACK, val, i % 4);
    end
    send_item(cbd_pkg::ACT_PUSH_FRONT, 8'h3C, 0);
    send_item(cbd_pkg::ACT_PUSH_BACK, 8'hC3, 0);
    send_item(ActSpareHi, 8'h81, 0);
  endtask

  function automatic logic [2:0] pick_action(bit filling);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 3'($urandom_range(ActSpareLo, ActSpareHi));
    if (roll < 20)
      return 3'($urandom_range(cbd_pkg::ACT_PEEK_FRONT, cbd_pkg::ACT_PEEK_BACK));
    if (filling ? (roll < 70) : (roll < 40))
      return 3'($urandom_range(cbd_pkg::ACT_PUSH_FRONT, cbd_pkg::ACT_PUSH_BACK));
    return 3'($urandom_range(cbd_pkg::ACT_POP_FRONT, cbd_pkg::ACT_POP_BACK));
  endfunction

  // Random traffic that sweeps between full and empty so that both ends wrap
  // many times; each block of items either idles at random or runs back to back.
  task automatic test_random_traffic(int unsigned n_items);
    bit          filling;
    bit          idling;
    int unsigned gap;
    filling = (held_count < Depth / 2);
    idling  = 1'b1;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % BlockLen == 0) idling = ($urandom_range(0, 2) != 0);
      if (i % 200 == 199) wait_results_drained();
      if (filling && held_count == Depth && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (!filling && held_count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) == 0) filling = !filling;
      gap = idling ? $urandom_range(0, 18) : 0;
      send_item(pick_action(filling), 8'($urandom), gap);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_edges();
    test_full_edges();
    test_random_traffic(1600);
    wait_results_drained();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("circular_byte_deque_unit regression: pass");
    end else begin
      $display("circular_byte_deque_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[%0t] timeout", $realtime);
    $display("circular_byte_deque_unit regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/cbd_pkg.sv
rtl/cbd_ctrl.sv
rtl/cbd_datapath.sv
rtl/circular_byte_deque_unit.sv
dv/circular_byte_deque_unit_tb.sv
